// ===== rtl/wpd_pkg.sv =====
// Package with the types, codes and lookup functions of the primitive decoder.
`timescale 1ns / 1ps

package wpd_pkg;

  // Kind codes of the value that starts on a byte. Codes above U64LE act as U8.
  typedef enum logic [3:0] {
    KIND_VU1   = 4'd0,
    KIND_VU7   = 4'd1,
    KIND_VU32  = 4'd2,
    KIND_VI7   = 4'd3,
    KIND_VI32  = 4'd4,
    KIND_VI64  = 4'd5,
    KIND_U8    = 4'd6,
    KIND_U32LE = 4'd7,
    KIND_U64LE = 4'd8
  } wpd_kind_e;

  typedef enum logic [1:0] {
    WPD_ST_OK        = 2'd0,
    WPD_ST_EXHAUSTED = 2'd1,
    WPD_ST_BAD_LEB   = 2'd2
  } wpd_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] value_kind;
    logic       buffer_end;
  } wpd_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } wpd_out_t;

  // One step's outcome from the decoder to the result register.
  typedef struct packed {
    logic     valid;
    wpd_out_t data;
  } wpd_res_t;

  // Largest number of bytes a LEB kind may take: ceil(N/7).
  function automatic logic [3:0] leb_max_bytes(logic [3:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_VU32, KIND_VI32: n = 4'd5;
      KIND_VI64:            n = 4'd10;
      default:              n = 4'd1;
    endcase
    return n;
  endfunction

  // Byte length of a raw little-endian kind.
  function automatic logic [3:0] raw_len(logic [3:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_U32LE: n = 4'd4;
      KIND_U64LE: n = 4'd8;
      default:    n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/wpd_in_stage.sv =====
// Input register of the primitive decoder.
`timescale 1ns / 1ps

module wpd_in_stage import wpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  wpd_in_t in_req_i,
  input  logic    advance_i,
  output logic    s1_valid_o,
  output wpd_in_t s1_req_o
);

  logic    valid_q, valid_d;
  wpd_in_t req_q;

  // The register takes a new request whenever the held one leaves or none is held.
  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_req_o   = req_q;

endmodule

// ===== rtl/wpd_decode.sv =====
// Byte decoder: value state and the single-pass LEB128 and raw word logic.
`timescale 1ns / 1ps

module wpd_decode import wpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  wpd_in_t  req_i,
  output wpd_res_t res_o
);

  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  kind_q, kind_d;
  logic        busy_q, busy_d;

  logic [3:0]  kind;
  logic [3:0]  cnt;
  logic [3:0]  cnt_inc;
  logic [63:0] acc;
  logic [6:0]  shift;
  logic [6:0]  shift_end;
  logic [63:0] acc_leb;
  logic [63:0] acc_raw;
  logic [63:0] sx;
  logic [63:0] leb_value;
  logic        is_leb;
  logic        done;
  wpd_out_t    out;

  always_comb begin
    kind      = busy_q ? kind_q : req_i.value_kind;
    cnt       = busy_q ? cnt_q : 4'd0;
    acc       = busy_q ? acc_q : 64'd0;
    cnt_inc   = cnt + 4'd1;
    shift     = 7'({3'b000, cnt} * 7'd7);
    shift_end = shift + 7'd7;
    is_leb    = (kind <= KIND_VI64);

    // Payload bits shifted past bit 63 fall off the top.
    acc_leb = acc | (64'(req_i.data_byte[6:0]) << shift);
    acc_raw = acc | (64'(req_i.data_byte) << {cnt[2:0], 3'b000});

    sx = acc_leb;
    if (shift_end < 7'd64 && req_i.data_byte[6]) begin
      sx = acc_leb | ({64{1'b1}} << shift_end[5:0]);
    end

    case (kind)
      KIND_VU32: leb_value = {32'd0, acc_leb[31:0]};
      KIND_VI7:  leb_value = {{56{sx[7]}}, sx[7:0]};
      KIND_VI32: leb_value = {{32{sx[31]}}, sx[31:0]};
      KIND_VI64: leb_value = sx;
      default:   leb_value = {56'd0, acc_leb[7:0]};
    endcase

    done       = 1'b0;
    out.value  = 64'd0;
    out.status = WPD_ST_OK;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    kind_d     = kind_q;
    busy_d     = busy_q;

    if (is_leb) begin
      if (!req_i.data_byte[7]) begin
        done      = 1'b1;
        out.value = leb_value;
      end else if (cnt_inc >= leb_max_bytes(kind)) begin
        done       = 1'b1;
        out.status = WPD_ST_BAD_LEB;
      end
    end else if (cnt_inc >= raw_len(kind)) begin
      done      = 1'b1;
      out.value = acc_raw;
    end

    // A buffer end before the value completes aborts it.
    if (!done && req_i.buffer_end) begin
      done       = 1'b1;
      out.status = WPD_ST_EXHAUSTED;
    end

    if (step_i) begin
      kind_d = kind;
      if (done) begin
        acc_d  = 64'd0;
        cnt_d  = 4'd0;
        busy_d = 1'b0;
      end else begin
        acc_d  = is_leb ? acc_leb : acc_raw;
        cnt_d  = cnt_inc;
        busy_d = 1'b1;
      end
    end

    res_o.valid = step_i && done;
    res_o.data  = out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 64'd0;
      cnt_q  <= 4'd0;
      kind_q <= 4'd0;
      busy_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      kind_q <= kind_d;
      busy_q <= busy_d;
    end
  end

  // An error result never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.status != WPD_ST_OK |-> res_o.data.value == 64'd0)
    else $error("error result with nonzero value");

  // Idle state always has an empty count and accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 4'd0 && acc_q == 64'd0)
    else $error("idle decoder holds partial value");

  // A value in progress never reaches the longest LEB limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < 4'd10)
    else $error("byte count out of range");

endmodule

// ===== rtl/wpd_out_stage.sv =====
// Result register of the primitive decoder.
`timescale 1ns / 1ps

module wpd_out_stage import wpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wpd_res_t res_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wpd_out_t out_req_o
);

  logic     valid_q, valid_d;
  wpd_out_t data_q;

  // The register can load when empty or when its request leaves this cycle.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = free_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

endmodule

// ===== rtl/wasm_primitive_decoder.sv =====
// Top level of the WebAssembly primitive (LEB128 and raw word) decoder.
//
//   Channel | Direction | Handshake                | Request type
//   --------+-----------+--------------------------+-------------
//   in      | input     | in_valid_i / in_stall_o  | wpd_in_t
//   out     | output    | out_valid_o / out_stall_i| wpd_out_t
//
// Each input request is one byte of a buffer. The byte goes into an input
// register, is decoded in one pass against the running value state, and any
// result lands in a result register. One byte is accepted in every cycle
// while the result side keeps up; the limit is the single decode pass
// between the two registers.
// Reset is asynchronous and active low; it empties both registers and
// leaves the decoder idle, waiting for the first byte of a value.
// When the result register is held by out_stall_i, the byte waiting in the
// input register stays, and in_stall_o rises only while that byte is held.
`timescale 1ns / 1ps

module wasm_primitive_decoder import wpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wpd_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wpd_out_t out_req_o
);

  logic     s1_valid;
  wpd_in_t  s1_req;
  logic     out_free;
  logic     step;
  wpd_res_t res;

  // The held byte is decoded only when the result register can take
  // whatever it produces, so the value state never runs ahead of the output.
  assign step = s1_valid && out_free;

  wpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .advance_i  (out_free),
    .s1_valid_o (s1_valid),
    .s1_req_o   (s1_req)
  );

  wpd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (s1_req),
    .res_o  (res)
  );

  wpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // The input side is held back only while a byte waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked byte");

  // A stalled result stays in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result lost or changed");

  // A decoded byte with a result always shows up on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_o)
    else $error("result dropped");

endmodule

// ===== tb/wasm_primitive_decoder_checker.sv =====
// Checker that predicts and compares every result of the primitive decoder.
`timescale 1ns / 1ps

module wasm_primitive_decoder_checker import wpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  wpd_in_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  wpd_out_t out_req_i,
  output int       fail_count_o,
  output int       pending_o
);

  bit [63:0] acc_q;
  bit [3:0]  count_q;
  bit [3:0]  kind_q;
  bit        busy_q;
  wpd_out_t  pending_results[$];

  // Runs one accepted byte through the decoder state and queues any result.
  task automatic decode_byte(input wpd_in_t req);
    int unsigned shift;
    bit [3:0]    limit;
    bit          done;
    wpd_out_t    res;
    done = 1'b0;
    res = '0;
    if (!busy_q) begin
      kind_q = req.value_kind;
      acc_q = '0;
      count_q = '0;
      busy_q = 1'b1;
    end
    case (kind_q)
      KIND_VU1, KIND_VU7, KIND_VU32, KIND_VI7, KIND_VI32, KIND_VI64: begin
        shift = count_q * 7;
        if (shift < 64) acc_q |= {57'd0, req.data_byte[6:0]} << shift;
        shift += 7;
        if (!req.data_byte[7]) begin
          done = 1'b1;
          res.value = acc_q;
          res.status = WPD_ST_OK;
          case (kind_q)
            KIND_VI7, KIND_VI32, KIND_VI64: begin
              if (shift < 64 && req.data_byte[6]) begin
                res.value |= ~((64'd1 << shift) - 64'd1);
              end
              if (kind_q == KIND_VI7) begin
                res.value = {{56{res.value[7]}}, res.value[7:0]};
              end else if (kind_q == KIND_VI32) begin
                res.value = {{32{res.value[31]}}, res.value[31:0]};
              end
            end
            KIND_VU32: res.value = {32'd0, res.value[31:0]};
            default:   res.value = {56'd0, res.value[7:0]};
          endcase
        end else begin
          case (kind_q)
            KIND_VU32, KIND_VI32: limit = 4'd5;
            KIND_VI64:            limit = 4'd10;
            default:              limit = 4'd1;
          endcase
          count_q = count_q + 4'd1;
          if (count_q >= limit) begin
            done = 1'b1;
            res.value = '0;
            res.status = WPD_ST_BAD_LEB;
          end
        end
      end
      default: begin
        case (kind_q)
          KIND_U32LE: limit = 4'd4;
          KIND_U64LE: limit = 4'd8;
          default:    limit = 4'd1;
        endcase
        acc_q |= {56'd0, req.data_byte} << {count_q[2:0], 3'b000};
        count_q = count_q + 4'd1;
        if (count_q >= limit) begin
          done = 1'b1;
          res.value = acc_q;
          res.status = WPD_ST_OK;
        end
      end
    endcase
    if (!done && req.buffer_end) begin
      done = 1'b1;
      res.value = '0;
      res.status = WPD_ST_EXHAUSTED;
    end
    if (done) begin
      pending_results.push_back(res);
      acc_q = '0;
      count_q = '0;
      busy_q = 1'b0;
    end
  endtask

  // Results are retired before the same edge's request is decoded, so a
  // result can never be matched against a request taken in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    wpd_out_t want;
    if (!rst_ni) begin
      acc_q = '0;
      count_q = '0;
      kind_q = '0;
      busy_q = 1'b0;
      pending_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value=%h status=%0d", out_req_i.value, out_req_i.status);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (out_req_i.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_req_i.value);
            fail_count_o++;
          end
          if (out_req_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_req_i.status);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_req_i);
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== tb/wasm_primitive_decoder_test.sv =====
// Top of the primitive decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The stimulus feeds byte requests into the decoder and lets the checker
// beside it predict and compare every result. It runs a short directed list
// first, then three random phases that differ only in how often each side
// idles: the sender idles more lightly than the receiver, then the other way
// round, then neither idles. Between phases the sender holds off until every
// expected result has come back, which also exercises a fully drained pipe.
module wasm_primitive_decoder_test;
  import wpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // Kind codes above the last defined one decode as a single raw byte.
  localparam logic [3:0] KIND_ABOVE_RANGE = 4'hf;

  // Shape of a random value: complete, too many LEB bytes, or cut short.
  typedef enum int {FORM_GOOD, FORM_LONG, FORM_CUT} value_form_e;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  wpd_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  wpd_out_t out_req_o;

  int fail_count;
  int pending_count;
  int sent_count;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  wasm_primitive_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  wasm_primitive_decoder_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_i    (out_req_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides once per cycle, at the falling edge, whether to
  // hold the result register. With the percentage at zero it never stalls.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // A hung handshake must not leave the run spinning forever.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("wasm_primitive_decoder verification failed");
        $finish;
      end
    end
  end

  function automatic wpd_in_t make_req(logic [7:0] data, logic [3:0] kind, logic last);
    wpd_in_t r;
    r.data_byte = data;
    r.value_kind = kind;
    r.buffer_end = last;
    return r;
  endfunction

  // Offers one request, starting at a falling edge. Idle cycles drop valid
  // first; once valid is up the request stays put until a rising edge finds
  // the decoder not stalling. Returns at the following falling edge.
  task automatic send_byte(input wpd_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until the checker has seen every expected result.
  // The extra falling edge keeps the next valid assignment in a later step.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends one random value. Most are well formed with random content, and
  // multi-byte LEB values take a random length up to their limit; the rest overrun the LEB
  // limit, end the buffer early, or are a lone noise byte of any kind.
  task automatic send_random_value;
    int          mode;
    int          n;
    int          limit;
    bit          is_leb;
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [3:0]  later_kind;
    logic        last;
    value_form_e form;
    mode = $urandom_range(99);
    if (mode < 5) begin
      send_byte(make_req(8'($urandom), 4'($urandom), $urandom_range(9) == 0));
    end else begin
      kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      is_leb = (kind <= KIND_VI64);
      case (kind)
        KIND_VU32, KIND_VI32: limit = 5;
        KIND_VI64:            limit = 10;
        KIND_U32LE:           limit = 4;
        KIND_U64LE:           limit = 8;
        default:              limit = 1;
      endcase
      form = (mode < 80) ? FORM_GOOD : (mode < 90) ? FORM_LONG : FORM_CUT;
      if (form == FORM_LONG && !is_leb) form = FORM_CUT;
      if (form == FORM_CUT && limit == 1) form = is_leb ? FORM_LONG : FORM_GOOD;
      case (form)
        FORM_GOOD: n = is_leb ? $urandom_range(1, limit) : limit;
        FORM_LONG: n = limit;
        default:   n = $urandom_range(1, limit - 1);
      endcase
      for (int i = 0; i < n; i++) begin
        data = 8'($urandom);
        // Lean on all-ones and all-zero payloads now and then.
        if ($urandom_range(7) == 0) data[6:0] = {7{data[0]}};
        if (is_leb) data[7] = (form != FORM_GOOD) || (i != n - 1);
        later_kind = 4'($urandom);
        if (i == n - 1) begin
          last = (form == FORM_CUT) ? 1'b1 : ($urandom_range(3) == 0);
        end else begin
          last = 1'b0;
        end
        send_byte(make_req(data, (i == 0) ? kind : later_kind, last));
      end
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_req_i = '0;
    rst_ni = 1'b0;
    sent_count = 0;
    send_idle_pct = 30;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed list: smallest and largest single-byte LEB values, the sign
    // bit of a one-byte signed value, a completing byte that also ends the
    // buffer, an overlong LEB byte that also ends the buffer (the overrun
    // wins), a two-byte negative varint, one- and four-byte raw words, a kind
    // code above the defined range, a raw word cut off by the buffer end,
    // and a varint64 that uses all ten bytes.
    send_byte(make_req(8'h00, KIND_VU1, 1'b0));
    send_byte(make_req(8'h7f, KIND_VU7, 1'b1));
    send_byte(make_req(8'h40, KIND_VI7, 1'b0));
    send_byte(make_req(8'h80, KIND_VU7, 1'b1));
    send_byte(make_req(8'h80, KIND_VI32, 1'b0));
    send_byte(make_req(8'h7f, KIND_VI32, 1'b0));
    send_byte(make_req(8'hff, KIND_U8, 1'b0));
    send_byte(make_req(8'ha5, KIND_ABOVE_RANGE, 1'b0));
    send_byte(make_req(8'h78, KIND_U32LE, 1'b0));
    send_byte(make_req(8'h56, KIND_U32LE, 1'b0));
    send_byte(make_req(8'h34, KIND_U32LE, 1'b0));
    send_byte(make_req(8'h12, KIND_U32LE, 1'b0));
    send_byte(make_req(8'h01, KIND_U64LE, 1'b0));
    send_byte(make_req(8'h02, KIND_U64LE, 1'b1));
    repeat (9) send_byte(make_req(8'hff, KIND_VI64, 1'b0));
    send_byte(make_req(8'h7f, KIND_VI64, 1'b0));

    while (sent_count < 540) send_random_value();
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 30;
    while (sent_count < 1045) send_random_value();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_count < 1550) send_random_value();
    drain();

    // Idle cycles after the last drain catch any stray result that should
    // not exist.
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("wasm_primitive_decoder verification clean");
    end else begin
      $display("wasm_primitive_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wpd_pkg.sv
rtl/wpd_in_stage.sv
rtl/wpd_decode.sv
rtl/wpd_out_stage.sv
rtl/wasm_primitive_decoder.sv
tb/wasm_primitive_decoder_checker.sv
tb/wasm_primitive_decoder_test.sv
